[rtl/qs_pkg.sv]
// Shared constants, types and sequencer states of the quicksort engine.
`default_nettype none

package qs_pkg;

  localparam int VALUE_W       = 32;
  localparam int IDX_W         = 6;
  localparam int ENTRY_W       = 2 * IDX_W;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_IRD,
    S_SCANI,
    S_SCANJ,
    S_SWAP2,
    S_FIN2,
    S_PUSHL,
    S_ORD,
    S_OHOLD
  } state_t;

endpackage

`default_nettype wire

[rtl/qs_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module qs_ram #(
  parameter int WIDTH = qs_pkg::VALUE_W,
  parameter int DEPTH = qs_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/qs_ctrl.sv]
// Sequencer: load, partition with range stack, and read-out of the sorted words.
`default_nettype none

module qs_ctrl #(
  parameter int MAX_ITEMS = qs_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire qs_pkg::value_t               value_in,
  input  wire logic                         last_in,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  output qs_pkg::value_t                    value_out,
  output logic                              last_out,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              st_we,
  output logic [$clog2(MAX_ITEMS)-1:0]      st_waddr,
  output qs_pkg::value_t                    st_wdata,
  output logic                              st_re,
  output logic [$clog2(MAX_ITEMS)-1:0]      st_raddr,
  input  wire qs_pkg::value_t               st_rdata,
  output logic                              sk_we,
  output logic [$clog2(MAX_ITEMS)-1:0]      sk_waddr,
  output qs_pkg::entry_t                    sk_wdata,
  output logic                              sk_re,
  output logic [$clog2(MAX_ITEMS)-1:0]      sk_raddr,
  input  wire qs_pkg::entry_t               sk_rdata
);

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);

  qs_pkg::state_t state, state_next;

  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  sp, sp_next;
  logic [CW-1:0]  k, k_next;
  logic [AW-1:0]  lo, lo_next;
  logic [AW-1:0]  hi, hi_next;
  logic [AW:0]    i, i_next;
  logic [AW-1:0]  j, j_next;
  qs_pkg::value_t pv, pv_next;
  qs_pkg::value_t vi, vi_next;
  qs_pkg::value_t value_out_next;
  logic           last_out_next;
  logic           out_valid_next;

  logic [AW:0]    i_inc;
  logic [AW:0]    j_ext;
  logic [AW:0]    hi_ext;
  logic [AW:0]    lo_ext;
  logic [AW:0]    j_inc;
  logic [AW-1:0]  j_dec;
  logic [CW-1:0]  sp_dec;
  logic [CW-1:0]  k_inc;
  logic [CW-1:0]  count_dec;
  logic           sp_room;
  logic           rd_le;
  logic           out_free;
  logic           in_fire;

  assign i_inc     = i + (AW+1)'(1);
  assign j_ext     = {1'b0, j};
  assign hi_ext    = {1'b0, hi};
  assign lo_ext    = {1'b0, lo};
  assign j_inc     = j_ext + (AW+1)'(1);
  assign j_dec     = j - AW'(1);
  assign sp_dec    = sp - CW'(1);
  assign k_inc     = k + CW'(1);
  assign count_dec = count - CW'(1);
  assign sp_room   = sp < CW'(MAX_ITEMS);
  assign rd_le     = st_rdata <= pv;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != qs_pkg::S_LOAD);
  assign in_fire   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      qs_pkg::S_LOAD: begin
        if (in_fire && (last_in || count >= CW'(MAX_ITEMS))) begin
          state_next = qs_pkg::S_START;
        end
      end
      qs_pkg::S_START: state_next = qs_pkg::S_POP;
      qs_pkg::S_POP: begin
        state_next = (sp == '0) ? qs_pkg::S_ORD : qs_pkg::S_RANGE;
      end
      qs_pkg::S_RANGE: state_next = qs_pkg::S_PIVOT;
      qs_pkg::S_PIVOT: state_next = qs_pkg::S_SCANI;
      qs_pkg::S_IRD: begin
        state_next = (i <= hi_ext) ? qs_pkg::S_SCANI : qs_pkg::S_SCANJ;
      end
      qs_pkg::S_SCANI: begin
        if (!(rd_le && i_inc <= hi_ext)) begin
          state_next = qs_pkg::S_SCANJ;
        end
      end
      qs_pkg::S_SCANJ: begin
        if (rd_le) begin
          state_next = (i > j_ext) ? qs_pkg::S_FIN2 : qs_pkg::S_SWAP2;
        end
      end
      qs_pkg::S_SWAP2: state_next = qs_pkg::S_IRD;
      qs_pkg::S_FIN2:  state_next = qs_pkg::S_PUSHL;
      qs_pkg::S_PUSHL: state_next = qs_pkg::S_POP;
      qs_pkg::S_ORD:   state_next = qs_pkg::S_OHOLD;
      qs_pkg::S_OHOLD: begin
        if (out_free) begin
          state_next = (k_inc == count) ? qs_pkg::S_LOAD : qs_pkg::S_ORD;
        end
      end
      default: state_next = qs_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    count_next     = count;
    sp_next        = sp;
    k_next         = k;
    lo_next        = lo;
    hi_next        = hi;
    i_next         = i;
    j_next         = j;
    pv_next        = pv;
    vi_next        = vi;
    value_out_next = value_out;
    last_out_next  = last_out;
    out_valid_next = out_valid && out_stall;
    st_we          = 1'b0;
    st_waddr       = '0;
    st_wdata       = st_rdata;
    st_re          = 1'b0;
    st_raddr       = '0;
    sk_we          = 1'b0;
    sk_waddr       = sp[AW-1:0];
    sk_wdata       = '0;
    sk_re          = 1'b0;
    sk_raddr       = sp_dec[AW-1:0];
    unique case (state)
      qs_pkg::S_LOAD: begin
        k_next = '0;
        if (in_fire && count < CW'(MAX_ITEMS)) begin
          st_we      = 1'b1;
          st_waddr   = count[AW-1:0];
          st_wdata   = value_in;
          count_next = count + CW'(1);
        end
      end
      qs_pkg::S_START: begin
        sp_next = '0;
        if (count >= CW'(2)) begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = qs_pkg::entry_t'(count_dec[AW-1:0]) << qs_pkg::IDX_W;
          sp_next  = CW'(1);
        end
      end
      qs_pkg::S_POP: begin
        if (sp != '0) begin
          sk_re   = 1'b1;
          sp_next = sp_dec;
        end
      end
      qs_pkg::S_RANGE: begin
        lo_next  = sk_rdata[AW-1:0];
        hi_next  = sk_rdata[qs_pkg::IDX_W+AW-1:qs_pkg::IDX_W];
        j_next   = sk_rdata[qs_pkg::IDX_W+AW-1:qs_pkg::IDX_W];
        st_re    = 1'b1;
        st_raddr = sk_rdata[AW-1:0];
      end
      qs_pkg::S_PIVOT: begin
        // the pivot itself always passes the left scan
        pv_next  = st_rdata;
        i_next   = lo_ext + (AW+1)'(1);
        st_re    = 1'b1;
        st_raddr = lo + AW'(1);
      end
      qs_pkg::S_IRD: begin
        st_re    = 1'b1;
        st_raddr = (i <= hi_ext) ? i[AW-1:0] : j;
      end
      qs_pkg::S_SCANI: begin
        st_re = 1'b1;
        if (rd_le) begin
          i_next   = i_inc;
          st_raddr = (i_inc <= hi_ext) ? i_inc[AW-1:0] : j;
        end else begin
          vi_next  = st_rdata;
          st_raddr = j;
        end
      end
      qs_pkg::S_SCANJ: begin
        if (!rd_le) begin
          j_next   = j_dec;
          st_re    = 1'b1;
          st_raddr = j_dec;
        end else if (i > j_ext) begin
          st_we    = 1'b1;
          st_waddr = lo;
        end else begin
          st_we    = 1'b1;
          st_waddr = i[AW-1:0];
        end
      end
      qs_pkg::S_SWAP2: begin
        st_we    = 1'b1;
        st_waddr = j;
        st_wdata = vi;
        i_next   = i_inc;
        j_next   = j_dec;
      end
      qs_pkg::S_FIN2: begin
        st_we    = 1'b1;
        st_waddr = j;
        st_wdata = pv;
        if (j_inc < hi_ext && sp_room) begin
          sk_we    = 1'b1;
          sk_wdata = (qs_pkg::entry_t'(hi) << qs_pkg::IDX_W)
                   | qs_pkg::entry_t'(j_inc[AW-1:0]);
          sp_next  = sp + CW'(1);
        end
      end
      qs_pkg::S_PUSHL: begin
        if (lo_ext + (AW+1)'(1) < j_ext && sp_room) begin
          sk_we    = 1'b1;
          sk_wdata = (qs_pkg::entry_t'(j_dec) << qs_pkg::IDX_W) | qs_pkg::entry_t'(lo);
          sp_next  = sp + CW'(1);
        end
      end
      qs_pkg::S_ORD: begin
        st_re    = 1'b1;
        st_raddr = k[AW-1:0];
      end
      qs_pkg::S_OHOLD: begin
        if (out_free) begin
          value_out_next = st_rdata;
          last_out_next  = (k_inc == count);
          out_valid_next = 1'b1;
          k_next         = k_inc;
          if (k_inc == count) begin
            count_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qs_pkg::S_LOAD;
      count     <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      sp        <= sp_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    lo        <= lo_next;
    hi        <= hi_next;
    i         <= i_next;
    j         <= j_next;
    pv        <= pv_next;
    vi        <= vi_next;
    value_out <= value_out_next;
    last_out  <= last_out_next;
  end

endmodule

`default_nettype wire

[rtl/quicksort_engine.sv]
// Quicksort engine top level: element RAM, range stack RAM and sequencer.
// Words are loaded one per cycle into the element RAM while in_stall is low; a word
// with last_in set, or any word arriving while MAX_ITEMS are already held (that word
// is dropped), starts the sort. Stack and pivot handling, the element scans and the
// exchanges of each pending range are all bound by the single read port of the
// element RAM; already ordered input is the slowest case. The sorted words then
// leave in ascending order, each read from the element RAM and held until the
// output register is free, the final one with last_out set, after which the
// engine takes a new set. in_stall stays high from the start of the sort until
// the final sorted word is in the output register. No clearing pass after reset.
`default_nettype none

module quicksort_engine #(
  parameter int MAX_ITEMS = qs_pkg::MAX_ITEMS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire qs_pkg::value_t value_in,
  input  wire logic           last_in,
  input  wire logic           in_valid,
  output logic                in_stall,
  output qs_pkg::value_t      value_out,
  output logic                last_out,
  output logic                out_valid,
  input  wire logic           out_stall
);

  localparam int AW = $clog2(MAX_ITEMS);

  logic           st_we;
  logic [AW-1:0]  st_waddr;
  qs_pkg::value_t st_wdata;
  logic           st_re;
  logic [AW-1:0]  st_raddr;
  qs_pkg::value_t st_rdata;
  logic           sk_we;
  logic [AW-1:0]  sk_waddr;
  qs_pkg::entry_t sk_wdata;
  logic           sk_re;
  logic [AW-1:0]  sk_raddr;
  qs_pkg::entry_t sk_rdata;

  qs_ram #(
    .WIDTH (qs_pkg::VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  qs_ram #(
    .WIDTH (qs_pkg::ENTRY_W),
    .DEPTH (MAX_ITEMS)
  ) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .re    (sk_re),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  qs_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .value_in  (value_in),
    .last_in   (last_in),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value_out (value_out),
    .last_out  (last_out),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_re     (st_re),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata),
    .sk_we     (sk_we),
    .sk_waddr  (sk_waddr),
    .sk_wdata  (sk_wdata),
    .sk_re     (sk_re),
    .sk_raddr  (sk_raddr),
    .sk_rdata  (sk_rdata)
  );

`ifndef SYNTHESIS
  // the element RAM is never read and written in the same cycle
  a_store_no_rw: assert property (@(posedge clk) disable iff (rst) !(st_we && st_re))
    else $error("element RAM read and write in the same cycle");

  a_stack_no_rw: assert property (@(posedge clk) disable iff (rst) !(sk_we && sk_re))
    else $error("stack RAM push and pop in the same cycle");

  a_load_no_read: assert property (@(posedge clk) disable iff (rst) !in_stall |-> !st_re)
    else $error("element RAM read while loading words");

  a_stack_idle_load: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(sk_we || sk_re))
    else $error("stack RAM access while loading words");
`endif

endmodule

`default_nettype wire

[tb/tb_quicksort_engine.sv]
// Testbench for quicksort_engine: directed table plus random sets, checked by a predictor.
`timescale 1ns / 1ps

module tb_quicksort_engine;

  typedef struct packed {
    qs_pkg::value_t value;
    logic           last;
  } sorted_word_t;

  typedef struct packed {
    qs_pkg::value_t value;
    logic           last;
    logic           typed;
    qs_pkg::value_t want;
  } row_t;

  localparam qs_pkg::value_t VMIN = 32'sh8000_0000;
  localparam qs_pkg::value_t VMAX = 32'sh7fff_ffff;
  localparam qs_pkg::value_t VNEG1 = 32'shffff_ffff;
  localparam int N_ROWS = 21;
  localparam int RANDOM_ITEMS = 140;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 200000;

  // typed rows are one-word sets, so the sorted word is the word itself
  localparam row_t DIRECTED [N_ROWS] = '{
    '{VMIN,  1'b1, 1'b1, VMIN},
    '{VMAX,  1'b1, 1'b1, VMAX},
    '{32'sd0, 1'b1, 1'b1, 32'sd0},
    '{VNEG1, 1'b1, 1'b1, VNEG1},
    '{32'sd5, 1'b0, 1'b0, 32'sd0},
    '{32'sd5, 1'b0, 1'b0, 32'sd0},
    '{32'sd5, 1'b1, 1'b0, 32'sd0},
    '{VMAX,  1'b0, 1'b0, 32'sd0},
    '{32'sd100, 1'b0, 1'b0, 32'sd0},
    '{-32'sd100, 1'b0, 1'b0, 32'sd0},
    '{VMIN,  1'b1, 1'b0, 32'sd0},
    '{VMIN,  1'b0, 1'b0, 32'sd0},
    '{VNEG1, 1'b0, 1'b0, 32'sd0},
    '{32'sd0, 1'b0, 1'b0, 32'sd0},
    '{VMAX,  1'b1, 1'b0, 32'sd0},
    '{32'sd3, 1'b0, 1'b0, 32'sd0},
    '{-32'sd3, 1'b0, 1'b0, 32'sd0},
    '{32'sd3, 1'b0, 1'b0, 32'sd0},
    '{-32'sd3, 1'b1, 1'b0, 32'sd0},
    '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
    '{32'shaaaa_aaaa, 1'b1, 1'b0, 32'sd0}
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  qs_pkg::value_t value_in = '0;
  logic           last_in = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  qs_pkg::value_t value_out;
  logic           last_out;
  logic           out_valid;
  logic           out_stall = 1'b0;

  qs_pkg::value_t held_vals [64];
  int held_n = 0;
  sorted_word_t sorted_q [$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int sets_sorted = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  quicksort_engine dut (
    .clk       (clk),
    .rst       (rst),
    .value_in  (value_in),
    .last_in   (last_in),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value_out (value_out),
    .last_out  (last_out),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("quicksort_engine test failed");
    $finish;
  end

  task automatic report(string msg);
    if (errors < 40) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic void swap_held(int a, int b);
    qs_pkg::value_t t;
    t = held_vals[a];
    held_vals[a] = held_vals[b];
    held_vals[b] = t;
  endfunction

  // first element is the pivot; scans meet, pivot goes to j
  function automatic int split_range(int lo, int hi);
    qs_pkg::value_t pv;
    int i;
    int j;
    pv = held_vals[lo];
    i = lo;
    j = hi;
    forever begin
      while (i <= hi && held_vals[i] <= pv) i++;
      while (j >= lo && held_vals[j] > pv) j--;
      if (i > j) break;
      swap_held(i, j);
    end
    swap_held(lo, j);
    return j;
  endfunction

  function automatic void sort_held();
    int lo_st [$];
    int hi_st [$];
    int lo;
    int hi;
    int p;
    if (held_n > 1) begin
      lo_st.push_back(0);
      hi_st.push_back(held_n - 1);
    end
    while (lo_st.size() > 0) begin
      lo = lo_st.pop_back();
      hi = hi_st.pop_back();
      p = split_range(lo, hi);
      if (p + 1 < hi && lo_st.size() < 64) begin
        lo_st.push_back(p + 1);
        hi_st.push_back(hi);
      end
      if (lo < p - 1 && lo_st.size() < 64) begin
        lo_st.push_back(lo);
        hi_st.push_back(p - 1);
      end
    end
  endfunction

  // a word arriving with the store full is dropped and triggers the sort
  function automatic void predict_sorted(qs_pkg::value_t v, logic l,
                                         ref sorted_word_t res [$]);
    res.delete();
    if (held_n < 64) begin
      held_vals[held_n] = v;
      held_n++;
      if (!l) return;
    end
    sort_held();
    for (int k = 0; k < held_n; k++) begin
      res.push_back(sorted_word_t'{value: held_vals[k], last: (k == held_n - 1)});
    end
    held_n = 0;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic offer(qs_pkg::value_t v, logic l, logic typed, qs_pkg::value_t want);
    sorted_word_t res [$];
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value_in <= v;
    last_in <= l;
    do @(posedge clk); while (in_stall);
    words_in++;
    predict_sorted(v, l, res);
    if (res.size() > 0) sets_sorted++;
    if (typed && res.size() == 1) begin
      sorted_q.push_back(sorted_word_t'{value: want, last: 1'b1});
    end else begin
      foreach (res[k]) sorted_q.push_back(res[k]);
    end
    @(negedge clk);
  endtask

  task automatic send_set(int size, bit overflow);
    int vals [];
    int mode;
    vals = new[size];
    mode = $urandom_range(0, 4);
    foreach (vals[k]) begin
      case (mode)
        1: vals[k] = int'($urandom_range(0, 7)) - 4;
        3: begin
          case ($urandom_range(0, 3))
            0: vals[k] = VMIN;
            1: vals[k] = VMAX;
            2: vals[k] = 0;
            default: vals[k] = -1;
          endcase
        end
        default: vals[k] = $urandom;
      endcase
    end
    if (mode == 2) vals.sort();
    if (mode == 4) vals.rsort();
    foreach (vals[k]) begin
      offer(vals[k], !overflow && (k == size - 1), 1'b0, '0);
    end
    if (overflow) offer($urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 20);
      end
    end
  end

  always @(posedge clk) begin
    sorted_word_t want;
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (sorted_q.size() == 0) begin
        report($sformatf("word %0d with nothing pending", value_out));
      end else begin
        want = sorted_q.pop_front();
        if (value_out !== want.value)
          report($sformatf("value_out %0d, want %0d", value_out, want.value));
        if (last_out !== want.last)
          report($sformatf("last_out %0b, want %0b", last_out, want.last));
      end
    end
  end

  initial begin
    int set_no;
    int waited;
    int left;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int r = 0; r < N_ROWS; r++) begin
      offer(DIRECTED[r].value, DIRECTED[r].last, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // long output hold while the next sets keep coming
    hold_req = 1'b1;
    set_no = 0;
    while (words_in - N_ROWS < RANDOM_ITEMS) begin
      calm = (set_no >= 4 && set_no < 11);
      left = RANDOM_ITEMS - (words_in - N_ROWS);
      if (set_no == 2) send_set(64, 1'b1);
      else if (left > 11 && $urandom_range(0, 9) == 0)
        send_set($urandom_range(11, (left < 64) ? left : 64), 1'b0);
      else send_set($urandom_range(1, 10), 1'b0);
      set_no++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    waited = 0;
    while (sorted_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sorted_q.size() != 0) report($sformatf("%0d sorted words never came", sorted_q.size()));
    repeat (50) @(posedge clk);

    $display("Run covered %0d input words in %0d sorted sets, %0d output words checked,",
             words_in, sets_sorted, words_out);
    $display("with one-word sets, duplicates, extremes, ordered runs and a store overflow.");
    if (errors == 0) begin
      $display("quicksort_engine test passed");
    end else begin
      $display("quicksort_engine test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/qs_pkg.sv
rtl/qs_ram.sv
rtl/qs_ctrl.sv
rtl/quicksort_engine.sv
tb/tb_quicksort_engine.sv
